FILE: rtl/core/tlv_app_param_parser_macros.svh
// Assertion macros shared by the parameter parser RTL.
`ifndef TLV_APP_PARAM_PARSER_MACROS_SVH
`define TLV_APP_PARAM_PARSER_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define TLV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define TLV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/tlv_pkg.sv
// Types, codes and the tag type table of the parameter parser.
package tlv_pkg;

    // result queue geometry
    localparam int unsigned QDepth  = 4;
    localparam int unsigned QIdxW   = $clog2(QDepth);
    localparam int unsigned QCntW   = $clog2(QDepth + 1);

    localparam logic [7:0] TAG_LAST_KNOWN = 8'h19;

    // parser phase, one-hot
    typedef enum logic [3:0] {
        PH_TAG   = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_VALUE = 4'b0100,
        PH_DROP  = 4'b1000
    } t_phase;

    // entry value type
    typedef enum logic [2:0] {
        TY_NONE = 3'd0,
        TY_U8   = 3'd1,
        TY_U16  = 3'd2,
        TY_U32  = 3'd3,
        TY_STR  = 3'd4
    } t_vtype;

    // result kind
    typedef enum logic [2:0] {
        K_NUM   = 3'd0,
        K_CHAR  = 3'd1,
        K_EMPTY = 3'd2,
        K_END   = 3'd3,
        K_ERR   = 3'd4
    } t_kind;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LEN   = 2'd1;
    localparam logic [1:0] ERR_TRUNC = 2'd2;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tag;
        logic [31:0] value;
        logic        send;
        logic [1:0]  code;
    } t_result;

    // up to two results caused by one input word
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_res_pair;

    // fixed tag table, tags 1..25
    function automatic t_vtype type_of_tag(input logic [7:0] tag);
        t_vtype ty;
        ty = TY_NONE;
        case (tag)
            8'd1, 8'd2, 8'd17, 8'd18:                       ty = TY_U16;
            8'd4, 8'd5, 8'd7, 8'd8, 8'd25:                  ty = TY_STR;
            8'd16:                                          ty = TY_U32;
            8'd3, 8'd6, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
            8'd14, 8'd15, 8'd19, 8'd20, 8'd21, 8'd22,
            8'd23, 8'd24:                                   ty = TY_U8;
            default:                                        ty = TY_NONE;
        endcase
        if (tag > TAG_LAST_KNOWN) begin
            ty = TY_NONE;
        end
        return ty;
    endfunction

    // length byte a numeric type asks for, zero if any length is fine
    function automatic logic [7:0] need_of(input t_vtype ty);
        logic [7:0] n;
        case (ty)
            TY_U8:   n = 8'd1;
            TY_U16:  n = 8'd2;
            TY_U32:  n = 8'd4;
            default: n = 8'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/core/tlv_parse.sv
// Entry parser: holds the header walk state and forms the results of each byte.
module tlv_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    output tlv_pkg::t_res_pair o_res
);
    import tlv_pkg::*;
    `include "tlv_app_param_parser_macros.svh"

    t_phase      r_phase, n_phase;
    logic [7:0]  r_tag, n_tag;
    t_vtype      r_type, n_type;
    logic [7:0]  r_left, n_left;
    logic [31:0] r_acc, n_acc;

    t_result     main_res, tail_res;
    logic        main_v, tail_v, end_chk, trunc;
    logic [7:0]  left_dec, need;

    // next state and results of the word on the input
    always_comb begin
        n_phase  = r_phase;
        n_tag    = r_tag;
        n_type   = r_type;
        n_left   = r_left;
        n_acc    = r_acc;
        main_v   = 1'b0;
        main_res = '{kind: K_NUM, tag: r_tag, value: 32'd0, send: 1'b0, code: ERR_NONE};
        end_chk  = 1'b0;
        trunc    = 1'b0;
        left_dec = r_left - 8'd1;
        need     = need_of(r_type);
        case (r_phase)
            PH_TAG: begin
                n_tag   = i_data;
                n_type  = type_of_tag(i_data);
                n_left  = 8'd0;
                n_acc   = 32'd0;
                n_phase = PH_LEN;
                trunc   = 1'b1;
                end_chk = 1'b1;
            end
            PH_LEN: begin
                n_left = i_data;
                if (need != 8'd0 && i_data != need) begin
                    // length mismatch: report, then drop to end of header
                    main_v        = 1'b1;
                    main_res.kind = K_ERR;
                    main_res.code = ERR_LEN;
                    n_phase       = i_last ? PH_TAG : PH_DROP;
                end else begin
                    end_chk = 1'b1;
                    if (i_data == 8'd0) begin
                        if (r_type == TY_STR) begin
                            main_v        = 1'b1;
                            main_res.kind = K_EMPTY;
                        end
                        n_phase = PH_TAG;
                    end else begin
                        n_phase = PH_VALUE;
                        trunc   = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                n_left  = left_dec;
                end_chk = 1'b1;
                if (r_type == TY_STR) begin
                    main_v         = 1'b1;
                    main_res.kind  = K_CHAR;
                    main_res.value = {24'd0, i_data};
                    main_res.send  = (left_dec == 8'd0);
                end else if (r_type != TY_NONE) begin
                    // big-endian assembly
                    n_acc = {r_acc[23:0], i_data};
                    if (left_dec == 8'd0) begin
                        main_v         = 1'b1;
                        main_res.kind  = K_NUM;
                        main_res.value = n_acc;
                    end
                end
                if (left_dec == 8'd0) begin
                    n_phase = PH_TAG;
                end else begin
                    trunc = 1'b1;
                end
            end
            PH_DROP: begin
                if (i_last) begin
                    n_phase = PH_TAG;
                end
            end
            default: begin
                n_phase = PH_TAG;
            end
        endcase

        // end of header: truncation error or end mark
        tail_v = end_chk && i_last;
        if (trunc) begin
            tail_res = '{kind: K_ERR, tag: n_tag, value: 32'd0, send: 1'b0, code: ERR_TRUNC};
        end else begin
            tail_res = '{kind: K_END, tag: 8'd0, value: 32'd0, send: 1'b0, code: ERR_NONE};
        end
        if (tail_v) begin
            n_phase = PH_TAG;
        end
    end

    // pack results in order
    always_comb begin
        if (main_v) begin
            o_res.r0  = main_res;
            o_res.r1  = tail_res;
            o_res.cnt = tail_v ? 2'd2 : 2'd1;
        end else begin
            o_res.r0  = tail_res;
            o_res.r1  = tail_res;
            o_res.cnt = {1'b0, tail_v};
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_tag   <= 8'd0;
            r_type  <= TY_NONE;
            r_left  <= 8'd0;
            r_acc   <= 32'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_type  <= n_type;
            r_left  <= n_left;
            r_acc   <= n_acc;
        end
    end

    `TLV_ASSERT(a_drop_silent, (i_accept && r_phase == PH_DROP) |-> (o_res.cnt == 2'd0), "drop phase produced a result")
    `TLV_ASSERT(a_second_is_tail, (o_res.cnt == 2'd2) |-> (o_res.r1.kind == K_END || o_res.r1.kind == K_ERR), "second result is not end or error")
    `TLV_ASSERT(a_last_rewinds, ($past(i_rst_n) && $past(i_accept && i_last)) |-> (r_phase == PH_TAG), "phase not back at tag after last word")

endmodule

FILE: rtl/core/tlv_res_fifo.sv
// Result queue: per cycle, takes up to two results if room, gives one if ready.
module tlv_res_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tlv_pkg::t_res_pair i_res,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output tlv_pkg::t_result   o_res
);
    import tlv_pkg::*;
    `include "tlv_app_param_parser_macros.svh"

    t_result            r_mem [QDepth];
    logic [QIdxW-1:0]   r_wr, n_wr;
    logic [QIdxW-1:0]   r_rd, n_rd;
    logic [QCntW-1:0]   r_count, n_count;
    logic [1:0]         push_n;
    logic               pop;
    logic [QIdxW-1:0]   wr_next;

    assign push_n  = i_push ? i_res.cnt : 2'd0;
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + 1'b1;
    assign o_valid = (r_count != '0);
    assign o_res   = r_mem[r_rd];
    // room for the worst case of two results
    assign o_room  = (r_count <= QCntW'(QDepth - 2));

    // pointer and fill count
    always_comb begin
        n_wr    = r_wr + QIdxW'(push_n);
        n_rd    = r_rd + QIdxW'(pop);
        n_count = r_count + QCntW'(push_n) - QCntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr] <= i_res.r0;
        end
        if (push_n == 2'd2) begin
            r_mem[wr_next] <= i_res.r1;
        end
    end

    `TLV_ASSERT(a_count_bound, r_count <= QCntW'(QDepth), "result queue overfilled")
    `TLV_ASSERT(a_push_fits, (i_push && i_res.cnt != 2'd0) |-> o_room, "push without room")
    `TLV_ASSERT(a_count_track, $past(i_rst_n) |-> (r_count == $past(n_count)), "fill count lost track")

endmodule

FILE: rtl/core/tlv_app_param_parser.sv
// Top level of the application-parameter header parser.
//
//  channel | dir | tdata                      | tuser    | tlast
//  s_axis  | in  | data_byte                  | -        | last_byte
//  m_axis  | out | param_tag, param_value,    | kind     | string_end
//          |     | error_code                 |          |
//
// One header byte is taken per clock while the queue has room; its results
// land in a four-word queue in the same cycle and leave one word per clock
// from the queue head. A byte that gives two results (a final byte) fills
// two queue words, so input ready drops when the queue holds more than two
// words. Reset (i_rst_n low, synchronous) empties the queue and rewinds the
// parser to expect a tag byte. An output stall holds the head word; input
// keeps flowing until the queue cannot take two more words.
module tlv_app_param_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] param_tag, [39:8] param_value,
                                        // [41:40] error_code, rest zero
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast    // string_end
);
    import tlv_pkg::*;

    t_res_pair res;
    t_result   head;
    logic      accept;
    logic      room;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    tlv_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_res    (res)
    );

    tlv_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_res   (res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (head)
    );

    // output word packing
    assign m_axis_tdata = {6'd0, head.code, head.value, head.tag};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.send;

endmodule
